### hdl/psls_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the per-source latency statistics block.
// No dependencies; every other file in hdl/ depends on this package.
package psls_pkg;

  localparam int NumSources = 16;
  localparam int IdxBits    = 4;
  localparam int CountBits  = 24;
  localparam int DelayBits  = 32;
  localparam int FcBits     = 5;
  localparam int ProdBits   = CountBits + DelayBits;
  localparam int NumBits    = ProdBits + 1;
  localparam int CntBits    = $clog2(DelayBits);

  localparam logic [FcBits-1:0]    FcReset  = FcBits'(NumSources);
  localparam logic [FcBits-1:0]    FcLimit  = FcBits'(NumSources);
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [CntBits-1:0]   DivLast  = CntBits'(DelayBits - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_SIMPLE,
    S_MUL,
    S_ADD,
    S_DIV,
    S_QUOT,
    S_WB,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic simple;
    logic mul;
    logic add;
    logic div_step;
    logic quot;
    logic wb;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic kind;
    logic first;
  } sts_t;

  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
    logic [CountBits-1:0] r;
    r = (v == CountMax) ? CountMax : v + CountBits'(1);
    return r;
  endfunction

endpackage

### hdl/psls_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces with valid/ready handshake.
// Depends on psls_pkg for field widths.
interface psls_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [psls_pkg::IdxBits-1:0]   source_index;
  logic [psls_pkg::DelayBits-1:0] delay;

  modport source (output valid, req_type, source_index, delay, input ready);
  modport sink   (input valid, req_type, source_index, delay, output ready);
endinterface

interface psls_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [psls_pkg::IdxBits-1:0]   source_id;
  logic [psls_pkg::CountBits-1:0] made_count;
  logic [psls_pkg::CountBits-1:0] eaten_count;
  logic [psls_pkg::DelayBits-1:0] min_delay;
  logic [psls_pkg::DelayBits-1:0] mean_delay;
  logic [psls_pkg::DelayBits-1:0] max_delay;
  logic                           count_mismatch;
  logic                           bad_index;

  modport source (output valid, source_id, made_count, eaten_count, min_delay, mean_delay,
                  max_delay, count_mismatch, bad_index, input ready);
  modport sink   (input valid, source_id, made_count, eaten_count, min_delay, mean_delay,
                  max_delay, count_mismatch, bad_index, output ready);
endinterface

### hdl/psls_datapath.sv
`timescale 1ns / 1ps
// Datapath: statistics tables, working registers, multiplier, radix-2 divider
// and response register. Depends on psls_pkg; driven by psls_ctrl commands.
module psls_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psls_pkg::FcBits-1:0]    cfg_wdata_i,
  input  psls_pkg::cmd_t                 cmd_i,
  output psls_pkg::sts_t                 sts_o,
  input  logic                           req_type_i,
  input  logic [psls_pkg::IdxBits-1:0]   source_index_i,
  input  logic [psls_pkg::DelayBits-1:0] delay_i,
  output logic [psls_pkg::IdxBits-1:0]   source_id_o,
  output logic [psls_pkg::CountBits-1:0] made_count_o,
  output logic [psls_pkg::CountBits-1:0] eaten_count_o,
  output logic [psls_pkg::DelayBits-1:0] min_delay_o,
  output logic [psls_pkg::DelayBits-1:0] mean_delay_o,
  output logic [psls_pkg::DelayBits-1:0] max_delay_o,
  output logic                           count_mismatch_o,
  output logic                           bad_index_o
);
  import psls_pkg::*;

  logic [FcBits-1:0]    fc_q;
  logic [CountBits-1:0] made_tab  [NumSources];
  logic [CountBits-1:0] eaten_tab [NumSources];
  logic [DelayBits-1:0] min_tab   [NumSources];
  logic [DelayBits-1:0] mean_tab  [NumSources];
  logic [DelayBits-1:0] max_tab   [NumSources];

  logic                 kind_q;
  logic [IdxBits-1:0]   idx_q;
  logic [DelayBits-1:0] dly_q;
  logic [CountBits-1:0] made_q;
  logic [CountBits-1:0] eaten_q;
  logic [DelayBits-1:0] min_q;
  logic [DelayBits-1:0] mean_q;
  logic [DelayBits-1:0] max_q;
  logic [ProdBits-1:0]  prod_q;
  logic [CountBits-1:0] rem_q;
  logic [DelayBits-1:0] quo_q;

  logic [IdxBits-1:0]   out_id_q;
  logic [CountBits-1:0] out_made_q;
  logic [CountBits-1:0] out_eaten_q;
  logic [DelayBits-1:0] out_min_q;
  logic [DelayBits-1:0] out_mean_q;
  logic [DelayBits-1:0] out_max_q;
  logic                 out_mis_q;
  logic                 out_bad_q;

  logic                 bad;
  logic [CountBits-1:0] nm1;
  logic [NumBits-1:0]   num;
  logic [CountBits:0]   shifted;
  logic [CountBits:0]   diff;
  logic                 ge;

  assign bad = ({1'b0, idx_q} >= fc_q) || ({1'b0, idx_q} >= FcLimit);
  assign nm1 = (eaten_q == CountMax) ? CountMax - CountBits'(1) : eaten_q;
  assign num = {1'b0, prod_q} + NumBits'(dly_q);

  assign shifted = {rem_q, quo_q[DelayBits-1]};
  assign ge      = shifted >= {1'b0, eaten_q};
  assign diff    = shifted - {1'b0, eaten_q};

  assign sts_o.bad   = bad;
  assign sts_o.kind  = kind_q;
  assign sts_o.first = (eaten_tab[idx_q] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= FcReset;
    end else if (cfg_we_i) begin
      fc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSources; i++) begin
        made_tab[i]  <= '0;
        eaten_tab[i] <= '0;
        min_tab[i]   <= '0;
        mean_tab[i]  <= '0;
        max_tab[i]   <= '0;
      end
    end else if (cmd_i.wb) begin
      made_tab[idx_q]  <= made_q;
      eaten_tab[idx_q] <= eaten_q;
      min_tab[idx_q]   <= min_q;
      mean_tab[idx_q]  <= mean_q;
      max_tab[idx_q]   <= max_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= req_type_i;
      idx_q  <= source_index_i;
      dly_q  <= delay_i;
    end
    if (cmd_i.load) begin
      made_q  <= made_tab[idx_q];
      eaten_q <= eaten_tab[idx_q];
      min_q   <= min_tab[idx_q];
      mean_q  <= mean_tab[idx_q];
      max_q   <= max_tab[idx_q];
    end
    if (cmd_i.simple) begin
      if (!kind_q) begin
        made_q <= sat_inc(made_q);
      end else begin
        eaten_q <= sat_inc(eaten_q);
        min_q   <= dly_q;
        mean_q  <= dly_q;
        max_q   <= dly_q;
      end
    end
    if (cmd_i.mul) begin
      eaten_q <= sat_inc(eaten_q);
      prod_q  <= ProdBits'(nm1) * ProdBits'(mean_q);
      if (dly_q < min_q) begin
        min_q <= dly_q;
      end
      if (dly_q > max_q) begin
        max_q <= dly_q;
      end
    end
    if (cmd_i.add) begin
      rem_q <= num[ProdBits-1:DelayBits];
      quo_q <= num[DelayBits-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[CountBits-1:0] : shifted[CountBits-1:0];
      quo_q <= {quo_q[DelayBits-2:0], ge};
    end
    if (cmd_i.quot) begin
      mean_q <= quo_q;
    end
    if (cmd_i.out_load) begin
      out_id_q <= idx_q;
      out_bad_q <= bad;
      if (bad) begin
        out_made_q  <= '0;
        out_eaten_q <= '0;
        out_min_q   <= '0;
        out_mean_q  <= '0;
        out_max_q   <= '0;
        out_mis_q   <= 1'b0;
      end else begin
        out_made_q  <= made_q;
        out_eaten_q <= eaten_q;
        out_min_q   <= min_q;
        out_mean_q  <= mean_q;
        out_max_q   <= max_q;
        out_mis_q   <= (made_q != eaten_q);
      end
    end
  end

  assign source_id_o      = out_id_q;
  assign made_count_o     = out_made_q;
  assign eaten_count_o    = out_eaten_q;
  assign min_delay_o      = out_min_q;
  assign mean_delay_o     = out_mean_q;
  assign max_delay_o      = out_max_q;
  assign count_mismatch_o = out_mis_q;
  assign bad_index_o      = out_bad_q;

endmodule

### hdl/psls_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences lookup, update, multiply, divide, write-back and response.
// Depends on psls_pkg; drives psls_datapath through cmd_t and reads sts_t.
module psls_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  logic           rsp_ready_i,
  output logic           rsp_valid_o,
  input  psls_pkg::sts_t sts_i,
  output psls_pkg::cmd_t cmd_o
);
  import psls_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               rsp_valid_q, rsp_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.load = 1'b1;
        if (sts_i.bad) begin
          state_d = S_RESP;
        end else if (!sts_i.kind || sts_i.first) begin
          state_d = S_SIMPLE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_SIMPLE: begin
        cmd_o.simple = 1'b1;
        state_d      = S_WB;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntBits'(1);
        if (cnt_q == DivLast) begin
          state_d = S_QUOT;
        end
      end
      S_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.out_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

### hdl/per_source_latency_stats_core.sv
`timescale 1ns / 1ps
// Top level of the per-source latency statistics block.
// Depends on psls_pkg, psls_if, psls_ctrl and psls_datapath.
//
// Keeps made/eaten counts and min, running mean and max consume delay (Q20.12 ms)
// for 16 sources, one response per request. Requests are handled one at a time;
// the response sits in an output register so the next request is taken while it
// waits. A produce request, a first consume sample of a source, or a rejected
// index is handled without the divider (a rejected index skips the table update).
// Every later consume request passes through the 32-step radix-2 divider that
// forms the truncated running mean. The tables clear at reset; no sweep.
module per_source_latency_stats_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psls_pkg::FcBits-1:0] cfg_wdata_i,
  psls_req_if.sink                    req,
  psls_rsp_if.source                  rsp
);
  import psls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  psls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_ready_i (rsp.ready),
    .rsp_valid_o (rsp.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  psls_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req.req_type),
    .source_index_i   (req.source_index),
    .delay_i          (req.delay),
    .source_id_o      (rsp.source_id),
    .made_count_o     (rsp.made_count),
    .eaten_count_o    (rsp.eaten_count),
    .min_delay_o      (rsp.min_delay),
    .mean_delay_o     (rsp.mean_delay),
    .max_delay_o      (rsp.max_delay),
    .count_mismatch_o (rsp.count_mismatch),
    .bad_index_o      (rsp.bad_index)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

  a_bad_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.bad_index) |->
      (rsp.made_count == '0 && rsp.eaten_count == '0 && rsp.mean_delay == '0 &&
       !rsp.count_mismatch))
    else $error("rejected request reports nonzero statistics");

  a_mean_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.bad_index) |->
      (rsp.min_delay <= rsp.mean_delay && rsp.mean_delay <= rsp.max_delay))
    else $error("mean delay outside min/max range");

endmodule
